/* sv/date_string_validator_defines.svh */
// ----------------------------------------------------------------------------
// Date string validator assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DATE_STRING_VALIDATOR_DEFINES_SVH
`define DATE_STRING_VALIDATOR_DEFINES_SVH

// Condition that must hold at every clock edge outside reset
`define DSV_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Condition that, once seen, forces a consequence at the next clock edge
`define DSV_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* sv/dsv_pkg.sv */
// ----------------------------------------------------------------------------
// Date string validator package
// Token types, field codes and character constants shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dsv_pkg;

  // Characters
  localparam logic [7:0] SlashChar = 8'h2F;
  localparam logic [7:0] DigitLo   = 8'h30;
  localparam logic [7:0] DigitHi   = 8'h39;

  // Field limits
  localparam logic [2:0] ShortDigitsMax = 3'd2;
  localparam logic [2:0] YearDigitsMax  = 3'd4;
  localparam logic [2:0] CountSat       = 3'd7;
  localparam logic [6:0] MonthMax       = 7'd12;
  localparam logic [6:0] DayMax         = 7'd31;
  localparam logic [6:0] FebLeapDay     = 7'd29;
  localparam logic [6:0] MonthFeb       = 7'd2;

  // Token queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    TOK_DIGIT,
    TOK_SLASH,
    TOK_OTHER
  } tok_kind_e;

  typedef enum logic [1:0] {
    FIELD_DAY,
    FIELD_MONTH,
    FIELD_YEAR
  } field_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] digit;
    logic       final_byte;
  } dsv_tok_t;

endpackage

`default_nettype wire

/* sv/dsv_front.sv */
// ----------------------------------------------------------------------------
// Date string validator front end
// Accepts input requests and classifies each byte into a parser token.
// ----------------------------------------------------------------------------
`default_nettype none

module dsv_front (
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        text_byte_i,
  input  wire logic              final_byte_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output dsv_pkg::dsv_tok_t      tok_o
);
  import dsv_pkg::*;

  logic [7:0] offset;

  // Hold off requests while the queue has no room
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  // Classify the byte
  always_comb begin
    offset           = text_byte_i - DigitLo;
    tok_o.digit      = offset[3:0];
    tok_o.final_byte = final_byte_i;
    if (text_byte_i == SlashChar) begin
      tok_o.kind = TOK_SLASH;
    end else if (text_byte_i inside {[DigitLo:DigitHi]}) begin
      tok_o.kind = TOK_DIGIT;
    end else begin
      tok_o.kind = TOK_OTHER;
    end
  end

endmodule

`default_nettype wire

/* sv/dsv_queue.sv */
// ----------------------------------------------------------------------------
// Date string validator token queue
// Short FIFO that decouples the classifier from the parser.
// ----------------------------------------------------------------------------
`default_nettype none
`include "date_string_validator_defines.svh"

module dsv_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  dsv_pkg::dsv_tok_t      push_tok_i,
  output logic                   full_o,
  output logic                   valid_o,
  output dsv_pkg::dsv_tok_t      pop_tok_o,
  input  wire logic              pop_i
);
  import dsv_pkg::*;

  dsv_tok_t               entry_q [QueueDepth];
  logic [QPtrW-1:0]       wptr_q, wptr_d;
  logic [QPtrW-1:0]       rptr_q, rptr_d;
  logic [QCntW-1:0]       count_q, count_d;

  assign full_o    = (count_q == QCntW'(QueueDepth));
  assign valid_o   = (count_q != '0);
  assign pop_tok_o = entry_q[rptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Store pushed tokens
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_tok_i;
    end
  end

  `DSV_ASSERT(a_no_overflow, !(push_i && full_o), "token pushed into full queue")
  `DSV_ASSERT(a_no_underflow, !(pop_i && !valid_o), "token popped from empty queue")
  `DSV_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + 1'b1,
                   "queue occupancy did not grow on push")
  `DSV_ASSERT(a_count_bound, count_q <= QCntW'(QueueDepth), "queue occupancy out of range")

endmodule

`default_nettype wire

/* sv/dsv_back.sv */
// ----------------------------------------------------------------------------
// Date string validator back end
// Parses tokens into day, month and year and judges the date on the last one.
// ----------------------------------------------------------------------------
`default_nettype none

module dsv_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  dsv_pkg::dsv_tok_t      q_tok_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   date_ok_o,
  output logic [6:0]             day_value_o,
  output logic [6:0]             month_value_o,
  output logic [13:0]            year_value_o
);
  import dsv_pkg::*;

  field_e      field_q, field_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [6:0]  day_q, day_d;
  logic [6:0]  mon_q, mon_d;
  logic [13:0] year_q, year_d;
  logic        err_q, err_d;
  logic [3:0]  yd_q [4];
  logic [3:0]  yd_d [4];

  logic        out_valid_q, out_valid_d;
  logic        ok_q;
  logic [6:0]  day_out_q, mon_out_q;
  logic [13:0] year_out_q;

  logic        slot_free;
  logic [2:0]  limit;
  logic [10:0] day_mul, mon_mul;
  logic [17:0] year_mul;
  logic        judge_ok;
  logic        is_leap;
  logic [1:0]  lo_mod4, hi_mod4;

  // Take a token when it needs no result slot or the slot frees up
  assign slot_free = ~out_valid_q | ~out_stall_i;
  assign pop_o     = q_valid_i & (~q_tok_i.final_byte | slot_free);

  // Step the parser state for one token
  always_comb begin
    field_d  = field_q;
    cnt_d    = cnt_q;
    day_d    = day_q;
    mon_d    = mon_q;
    year_d   = year_q;
    err_d    = err_q;
    yd_d     = yd_q;
    limit    = (field_q == FIELD_YEAR) ? YearDigitsMax : ShortDigitsMax;
    day_mul  = {4'd0, day_q} * 11'd10 + {7'd0, q_tok_i.digit};
    mon_mul  = {4'd0, mon_q} * 11'd10 + {7'd0, q_tok_i.digit};
    year_mul = {4'd0, year_q} * 18'd10 + {14'd0, q_tok_i.digit};
    case (q_tok_i.kind)
      TOK_SLASH: begin
        if (field_q == FIELD_YEAR) begin
          err_d = 1'b1;
        end else begin
          if (cnt_q < 3'd1 || cnt_q > ShortDigitsMax) begin
            err_d = 1'b1;
          end
          field_d = (field_q == FIELD_DAY) ? FIELD_MONTH : FIELD_YEAR;
          cnt_d   = '0;
        end
      end
      TOK_DIGIT: begin
        if (cnt_q >= limit) begin
          err_d = 1'b1;
        end else begin
          case (field_q)
            FIELD_DAY:   day_d = day_mul[6:0];
            FIELD_MONTH: mon_d = mon_mul[6:0];
            default: begin
              year_d = year_mul[13:0];
              yd_d[3] = yd_q[2];
              yd_d[2] = yd_q[1];
              yd_d[1] = yd_q[0];
              yd_d[0] = q_tok_i.digit;
            end
          endcase
        end
        if (cnt_q != CountSat) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        err_d = 1'b1;
      end
    endcase
  end

  // Judge the date from the post-token state; the year digits give the leap test
  always_comb begin
    lo_mod4  = {yd_d[1][0], 1'b0} + yd_d[0][1:0];
    hi_mod4  = {yd_d[3][0], 1'b0} + yd_d[2][1:0];
    if (lo_mod4 != 2'd0) begin
      is_leap = 1'b0;
    end else if (yd_d[1] != 4'd0 || yd_d[0] != 4'd0) begin
      is_leap = 1'b1;
    end else begin
      is_leap = (hi_mod4 == 2'd0);
    end
    judge_ok = 1'b1;
    if (err_d || field_d != FIELD_YEAR) begin
      judge_ok = 1'b0;
    end
    if (cnt_d != ShortDigitsMax && cnt_d != YearDigitsMax) begin
      judge_ok = 1'b0;
    end
    if (mon_d < 7'd1 || mon_d > MonthMax) begin
      judge_ok = 1'b0;
    end
    if (day_d < 7'd1 || day_d > DayMax) begin
      judge_ok = 1'b0;
    end
    if (mon_d inside {7'd4, 7'd6, 7'd9, 7'd11} && day_d == DayMax) begin
      judge_ok = 1'b0;
    end
    if (mon_d == MonthFeb) begin
      if (day_d > FebLeapDay) begin
        judge_ok = 1'b0;
      end
      if (day_d == FebLeapDay && !is_leap) begin
        judge_ok = 1'b0;
      end
    end
  end

  // Hold or drop the result slot
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o && q_tok_i.final_byte) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Parser state; clear after the last token of a string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q     <= FIELD_DAY;
      cnt_q       <= '0;
      day_q       <= '0;
      mon_q       <= '0;
      year_q      <= '0;
      err_q       <= 1'b0;
      yd_q        <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        if (q_tok_i.final_byte) begin
          field_q <= FIELD_DAY;
          cnt_q   <= '0;
          day_q   <= '0;
          mon_q   <= '0;
          year_q  <= '0;
          err_q   <= 1'b0;
          yd_q    <= '{default: '0};
        end else begin
          field_q <= field_d;
          cnt_q   <= cnt_d;
          day_q   <= day_d;
          mon_q   <= mon_d;
          year_q  <= year_d;
          err_q   <= err_d;
          yd_q    <= yd_d;
        end
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (pop_o && q_tok_i.final_byte) begin
      ok_q       <= judge_ok;
      day_out_q  <= day_d;
      mon_out_q  <= mon_d;
      year_out_q <= year_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign date_ok_o     = ok_q;
  assign day_value_o   = day_out_q;
  assign month_value_o = mon_out_q;
  assign year_value_o  = year_out_q;

endmodule

`default_nettype wire

/* sv/date_string_validator.sv */
// After its final byte is accepted, a result passes through the token queue and then the result register.
// Throughput: one byte per cycle while the token queue has room; the parser in the back end takes one token
// per cycle and only stalls when the result register is full and stalled.
// A two-entry token queue lets the front keep accepting during such a stall until the queue is full.
// Reset (rst_ni low, asynchronous) empties the queue and result slot and
// returns the parser to the day field with cleared values.
// ----------------------------------------------------------------------------
// Date string validator
// Parses a d/m/y string byte by byte and reports one Gregorian check per string.
// ----------------------------------------------------------------------------
`default_nettype none

module date_string_validator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        final_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             date_ok_o,
  output logic [6:0]       day_value_o,
  output logic [6:0]       month_value_o,
  output logic [13:0]      year_value_o
);
  import dsv_pkg::*;

  logic     q_full, q_push, q_valid, q_pop;
  dsv_tok_t push_tok, pop_tok;

  // Classify incoming requests
  dsv_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_byte_i  (text_byte_i),
    .final_byte_i (final_byte_i),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .tok_o        (push_tok)
  );

  // Buffer tokens between the two sides
  dsv_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_tok_i (push_tok),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .pop_tok_o  (pop_tok),
    .pop_i      (q_pop)
  );

  // Parse and judge
  dsv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_tok_i       (pop_tok),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .date_ok_o     (date_ok_o),
    .day_value_o   (day_value_o),
    .month_value_o (month_value_o),
    .year_value_o  (year_value_o)
  );

endmodule

`default_nettype wire
